// ----- rtl/core/ravg_pkg.sv -----
// Shared types and constants for the range averaging filter.
// Holds transaction payload structs, controller/datapath command and status
// structs, and the register map. No dependencies.
package ravg_pkg;

  // Default ring length
  localparam int unsigned WINDOW_LEN_DEF = 20;

  // Field widths fixed by the sensor interface
  localparam int unsigned RANGE_W = 13;
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;

  // Sensor codes
  localparam logic [3:0]         PHASE_FAIL_STATUS = 4'd4;
  localparam logic [RANGE_W-1:0] OUT_OF_RANGE_MM   = 13'd8191;
  localparam logic [DIST_W-1:0]  INVALID_DIST      = 16'hFFFF;

  // Register reset values
  localparam logic [CFG_W-1:0] OFFSET_RESET = 16'd0;
  localparam logic [CFG_W-1:0] WAIT_RESET   = 16'd3000;

  // Register map, selected by paddr[2]
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_OFFSET = 1'b0;
  localparam logic REG_WAIT   = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]  now_ms;
    logic [RANGE_W-1:0] range_mm;
    logic [3:0]         range_status;
    logic               want_average;
  } in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance_mm;
    logic              sensor_enable;
    logic              sensor_working;
  } out_t;

  // How the answer of the current transaction is formed
  typedef enum logic [1:0] {
    K_INVALID = 2'd0,
    K_FROZEN  = 2'd1,
    K_SAMPLE  = 2'd2,
    K_AVG     = 2'd3
  } kind_e;

  typedef struct packed {
    logic capture;  // take the input transaction, read old ring entry
    logic eval;     // check wait, status and freeze, update the window
    logic mul;      // multiply sum by the reciprocal of the ring length
    logic load;     // load the output register
  } cmd_t;

  typedef struct packed {
    logic early;    // answer needs no average
  } sts_t;

endpackage

// ----- rtl/core/ravg_ctrl.sv -----
// Controller of the range averaging filter: one-hot sequencer and the
// valid flag of the output register. Depends on ravg_pkg.
module ravg_ctrl
  import ravg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_MUL  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Decode commands from the state
  always_comb begin
    cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
    cmd_o.eval    = (state_q == S_EVAL);
    cmd_o.mul     = (state_q == S_MUL);
    cmd_o.load    = (state_q == S_OUT) && out_free;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EVAL;
      S_EVAL: state_d = sts_i.early ? S_OUT : S_MUL;
      S_MUL:  state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the result until the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/core/ravg_dp.sv -----
// Datapath of the range averaging filter: sample ring memory, running sum,
// repeat-run tracker for freeze detection, power-off timer and result
// register. Depends on ravg_pkg.
module ravg_dp
  import ravg_pkg::*;
#(
  parameter int unsigned WindowLen = WINDOW_LEN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  in_t              in_data_i,
  input  logic [CFG_W-1:0] offset_i,
  input  logic [CFG_W-1:0] wait_i,
  output out_t             out_data_o
);

  localparam int unsigned SLOT_W   = $clog2(WindowLen);
  localparam int unsigned RUN_W    = $clog2(WindowLen + 1);
  localparam int unsigned SUM_W    = RANGE_W + SLOT_W;
  // floor(x / WindowLen) == (x * RecipM) >> RecipSh for every x below 2**SUM_W
  localparam int unsigned RecipSh  = SUM_W + SLOT_W;
  localparam int unsigned RecipInt = ((1 << RecipSh) + WindowLen - 1) / WindowLen;
  localparam int unsigned PROD_W   = SUM_W + RecipSh;

  localparam logic [RecipSh-1:0] RecipM   = RecipSh'(RecipInt);
  localparam logic [SLOT_W-1:0]  LastSlot = SLOT_W'(WindowLen - 1);
  localparam logic [RUN_W-1:0]   RunFull  = RUN_W'(WindowLen);

  // Ring storage, written and read in clocked blocks
  logic [RANGE_W-1:0] ring_mem [WindowLen];
  logic [RANGE_W-1:0] rd_q;

  in_t                in_q;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic               wrapped_q, wrapped_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [RUN_W-1:0]   run_q, run_d;
  logic [RANGE_W-1:0] last_q, last_d;
  logic               resetting_q, resetting_d;
  logic [TIME_W-1:0]  pot_q, pot_d;
  logic               enable_q, enable_d;
  logic               working_q, working_d;
  kind_e              kind_q, kind_d;
  logic [PROD_W-1:0]  prod_q;
  out_t               out_q;

  logic [TIME_W-1:0]  elapsed;
  logic               waiting, phase_fail, frozen, do_write;
  logic [RANGE_W-1:0] old_entry;
  logic [RUN_W-1:0]   run_nx;
  logic [RANGE_W-1:0] avg_q;
  logic [DIST_W-1:0]  base, answer;

  // Check the power-off wait and the sensor status
  assign elapsed    = in_q.now_ms - pot_q;
  assign waiting    = resetting_q && (elapsed < {{(TIME_W-CFG_W){1'b0}}, wait_i});
  assign phase_fail = (in_q.range_status == PHASE_FAIL_STATUS);
  assign do_write   = cmd_i.eval && !waiting && !phase_fail;

  // Entries not yet written since reset read as zero
  assign old_entry = wrapped_q ? rd_q : '0;

  // Track how many latest writes repeat the newest sample
  always_comb begin
    if (in_q.range_mm != last_q) begin
      run_nx = RUN_W'(1);
    end else if (run_q == RunFull) begin
      run_nx = RunFull;
    end else begin
      run_nx = run_q + 1'b1;
    end
  end

  assign frozen = (run_nx == RunFull) && (in_q.range_mm != '0)
                  && (in_q.range_mm != OUT_OF_RANGE_MM);

  // Pick the kind of answer
  always_comb begin
    priority if (waiting || phase_fail) begin
      kind_d = K_INVALID;
    end else if (frozen) begin
      kind_d = K_FROZEN;
    end else if (in_q.want_average) begin
      kind_d = K_AVG;
    end else begin
      kind_d = K_SAMPLE;
    end
  end

  assign sts_o.early = (kind_d != K_AVG);

  // Next window and power state
  always_comb begin
    slot_d      = slot_q;
    wrapped_d   = wrapped_q;
    sum_d       = sum_q;
    run_d       = run_q;
    last_d      = last_q;
    resetting_d = resetting_q;
    pot_d       = pot_q;
    enable_d    = enable_q;
    working_d   = working_q;
    if (cmd_i.eval && !waiting) begin
      // wait over: power the sensor back on
      resetting_d = 1'b0;
      enable_d    = 1'b1;
      working_d   = 1'b1;
      if (!phase_fail) begin
        sum_d   = sum_q - SUM_W'(old_entry) + SUM_W'(in_q.range_mm);
        run_d   = run_nx;
        last_d  = in_q.range_mm;
        if (slot_q == LastSlot) begin
          slot_d    = '0;
          wrapped_d = 1'b1;
        end else begin
          slot_d = slot_q + 1'b1;
        end
        if (frozen) begin
          resetting_d = 1'b1;
          pot_d       = in_q.now_ms;
          enable_d    = 1'b0;
          working_d   = 1'b0;
        end
      end
    end
  end

  // Form the answer
  assign avg_q = prod_q[RecipSh +: RANGE_W];

  always_comb begin
    base   = {{(DIST_W-RANGE_W){1'b0}}, in_q.range_mm};
    answer = INVALID_DIST;
    unique case (kind_q)
      K_INVALID: answer = INVALID_DIST;
      K_FROZEN:  answer = base + offset_i;
      K_SAMPLE:  answer = base + offset_i;
      K_AVG:     answer = {{(DIST_W-RANGE_W){1'b0}}, avg_q} + offset_i;
      default:   answer = INVALID_DIST;
    endcase
  end

  // Ring write and read of the entry about to be replaced
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      ring_mem[slot_q] <= in_q.range_mm;
    end
    if (cmd_i.capture) begin
      rd_q <= ring_mem[slot_q];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
    if (cmd_i.eval) begin
      kind_q <= kind_d;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(sum_q) * PROD_W'(RecipM);
    end
    if (cmd_i.load) begin
      out_q.distance_mm    <= answer;
      out_q.sensor_enable  <= enable_q;
      out_q.sensor_working <= working_q;
    end
  end

  // Window and power state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      wrapped_q   <= 1'b0;
      sum_q       <= '0;
      run_q       <= RunFull;
      last_q      <= '0;
      resetting_q <= 1'b0;
      pot_q       <= '0;
      enable_q    <= 1'b1;
      working_q   <= 1'b1;
    end else begin
      slot_q      <= slot_d;
      wrapped_q   <= wrapped_d;
      sum_q       <= sum_d;
      run_q       <= run_d;
      last_q      <= last_d;
      resetting_q <= resetting_d;
      pot_q       <= pot_d;
      enable_q    <= enable_d;
      working_q   <= working_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- rtl/core/range_avg_with_freeze_reset.sv -----
// Top level of the range averaging filter with freeze detection.
// Holds the APB register file; instantiates ravg_ctrl and ravg_dp.
// Depends on ravg_pkg.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o   in_data_i  (in_t)
//   out       output     out_valid_o / out_stall_i out_data_o (out_t)
//   config    input      APB psel/penable/pready   pwdata, prdata (32 bits)
//
// A transaction steps the sequencer through capture plus ring read, evaluate and
// update, the reciprocal multiplier when the window average is answered, and
// result load. The next transaction is taken the cycle after the load.
// The result register frees the input while the last answer waits; a stalled
// output holds the sequencer in its load step.
// Reset clears the window to zero at once through a fill flag, with no
// clearing pass; the sensor starts powered and considered working.
module range_avg_with_freeze_reset
  import ravg_pkg::*;
#(
  parameter int unsigned WindowLen = WINDOW_LEN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [CFG_W-1:0] offset_q, offset_d;
  logic [CFG_W-1:0] wait_q, wait_d;
  logic             cfg_we;
  cmd_t             cmd;
  sts_t             sts;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  // Register writes
  always_comb begin
    offset_d = offset_q;
    wait_d   = wait_q;
    if (cfg_we) begin
      unique case (paddr[2])
        REG_OFFSET: offset_d = pwdata[CFG_W-1:0];
        REG_WAIT:   wait_d   = pwdata[CFG_W-1:0];
        default:    offset_d = offset_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_RESET;
      wait_q   <= WAIT_RESET;
    end else begin
      offset_q <= offset_d;
      wait_q   <= wait_d;
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[2])
      REG_OFFSET: prdata = {{(32-CFG_W){1'b0}}, offset_q};
      REG_WAIT:   prdata = {{(32-CFG_W){1'b0}}, wait_q};
      default:    prdata = '0;
    endcase
  end

  ravg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ravg_dp #(
    .WindowLen (WindowLen)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .offset_i   (offset_q),
    .wait_i     (wait_q),
    .out_data_o (out_data_o)
  );

endmodule

// ----- dv/range_avg_checker.sv -----
// Checker for the range averaging filter: watches the in, out and APB ports,
// predicts each answer and compares it field by field with the block's result.
// Depends on ravg_pkg.
module range_avg_checker
  import ravg_pkg::*;
#(
  parameter int unsigned WinLen = WINDOW_LEN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  in_t                in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_t               out_data_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int unsigned        n_fail_o,
  output int unsigned        n_pending_o
);

  // Shadow copy of the registers and of the filter state
  logic [CFG_W-1:0]   offset_mm;
  logic [CFG_W-1:0]   wait_ms;
  logic [RANGE_W-1:0] samples [WinLen];
  int unsigned        next_slot;
  int unsigned        samples_sum;
  logic               powered_down;
  logic [TIME_W-1:0]  power_off_at;
  logic               enable_lvl;
  logic               working_lvl;

  out_t               expected_dist_q [$];
  int unsigned        fail_cnt = 0;

  assign n_fail_o = fail_cnt;

  task automatic report_error(input string msg);
    $display("checker: %s", msg);
    fail_cnt++;
  endtask

  // Advance the shadow filter by one input transaction and form its answer
  task automatic filter_step(input in_t d, output out_t r);
    logic [TIME_W-1:0]  elapsed;
    logic [RANGE_W-1:0] head;
    logic [DIST_W-1:0]  answer;
    logic               same;
    elapsed = d.now_ms - power_off_at;
    if (powered_down && elapsed < TIME_W'(wait_ms)) begin
      answer = INVALID_DIST;
    end else begin
      // power-off wait is over: bring the sensor back
      if (powered_down) begin
        powered_down = 1'b0;
        enable_lvl   = 1'b1;
        working_lvl  = 1'b1;
      end
      if (d.range_status == PHASE_FAIL_STATUS) begin
        answer = INVALID_DIST;
      end else begin
        samples_sum        = samples_sum - samples[next_slot] + d.range_mm;
        samples[next_slot] = d.range_mm;
        next_slot          = (next_slot == WinLen - 1) ? 0 : next_slot + 1;
        head = samples[0];
        same = 1'b1;
        foreach (samples[i]) begin
          if (samples[i] != head) same = 1'b0;
        end
        // whole window stuck on one in-range value: power the sensor off
        if (same && head != '0 && head != OUT_OF_RANGE_MM) begin
          powered_down = 1'b1;
          enable_lvl   = 1'b0;
          working_lvl  = 1'b0;
          power_off_at = d.now_ms;
          answer       = DIST_W'(head) + offset_mm;
        end else if (d.want_average) begin
          answer = DIST_W'(samples_sum / WinLen) + offset_mm;
        end else begin
          answer = DIST_W'(d.range_mm) + offset_mm;
        end
      end
    end
    r.distance_mm    = answer;
    r.sensor_enable  = enable_lvl;
    r.sensor_working = working_lvl;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_t got;
    out_t want;
    out_t pred;
    if (!rst_ni) begin
      offset_mm    = OFFSET_RESET;
      wait_ms      = WAIT_RESET;
      foreach (samples[i]) samples[i] = '0;
      next_slot    = 0;
      samples_sum  = 0;
      powered_down = 1'b0;
      power_off_at = '0;
      enable_lvl   = 1'b1;
      working_lvl  = 1'b1;
      expected_dist_q.delete();
      n_pending_o <= 0;
    end else begin
      // track register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_WAIT) wait_ms = pwdata[CFG_W-1:0];
        else offset_mm = pwdata[CFG_W-1:0];
      end
      // compare an accepted result with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (expected_dist_q.size() == 0) begin
          report_error($sformatf("result %h with nothing expected", got));
        end else begin
          want = expected_dist_q.pop_front();
          if (got.distance_mm !== want.distance_mm)
            report_error($sformatf("distance_mm %h, expected %h",
                                   got.distance_mm, want.distance_mm));
          if (got.sensor_enable !== want.sensor_enable)
            report_error($sformatf("sensor_enable %b, expected %b",
                                   got.sensor_enable, want.sensor_enable));
          if (got.sensor_working !== want.sensor_working)
            report_error($sformatf("sensor_working %b, expected %b",
                                   got.sensor_working, want.sensor_working));
        end
      end
      // predict the answer of an accepted input transaction
      if (in_valid_i && !in_stall_i) begin
        filter_step(in_data_i, pred);
        expected_dist_q.push_back(pred);
      end
      n_pending_o <= expected_dist_q.size();
    end
  end

endmodule

// ----- dv/range_avg_with_freeze_reset_tb.sv -----
// Testbench top for the range averaging filter: clock, reset, APB register
// writes, sample stimulus and output stall; range_avg_checker does the checks.
// Depends on ravg_pkg, range_avg_with_freeze_reset and range_avg_checker.
module range_avg_with_freeze_reset_tb;
  import ravg_pkg::*;

  localparam int unsigned CycleLimit = 400_000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  in_t                in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_t               out_data_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  int unsigned        n_fail;
  int unsigned        n_pending;
  int unsigned        cycles        = 0;
  int unsigned        in_idle_pct   = 37;
  int unsigned        out_idle_pct  = 85;
  int unsigned        items_sent    = 0;
  int unsigned        cur_wait      = WAIT_RESET;
  logic [TIME_W-1:0]  now_q         = '0;

  range_avg_with_freeze_reset u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  range_avg_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .n_fail_o(n_fail), .n_pending_o(n_pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stall the output at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < out_idle_pct);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [3:0] ok_status();
    logic [3:0] st;
    st = 4'($urandom_range(0, 14));
    if (st >= PHASE_FAIL_STATUS) st++;
    return st;
  endfunction

  // Offer one sample at the current time and hold it until accepted
  task automatic send_sample(input logic [RANGE_W-1:0] mm, input logic [3:0] st,
                             input logic avg);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{now_ms: now_q, range_mm: mm, range_status: st, want_average: avg};
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Hold off the input until every pending answer has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (n_pending != 0) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic sel, input logic [CFG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {16'h0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Repeat one value to fill the window, then probe the power-off wait
  task automatic freeze_run();
    logic [RANGE_W-1:0] v;
    logic [TIME_W-1:0]  freeze_at;
    int unsigned        sel;
    int unsigned        len;
    logic               broken;
    sel    = $urandom_range(0, 11);
    v      = (sel == 0) ? '0 : (sel == 1) ? OUT_OF_RANGE_MM :
             RANGE_W'($urandom_range(1, OUT_OF_RANGE_MM - 1));
    broken = ($urandom_range(0, 5) == 0);
    len    = broken ? $urandom_range(3, WINDOW_LEN_DEF - 1)
                    : WINDOW_LEN_DEF + $urandom_range(0, 2);
    // leave any earlier wait, sometimes right before the time wraps
    if ($urandom_range(0, 7) == 0) now_q = '1 - TIME_W'($urandom_range(0, 24));
    else now_q = now_q + cur_wait + 1;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_sample(RANGE_W'($urandom), PHASE_FAIL_STATUS, 1'($urandom));
      now_q = now_q + $urandom_range(0, 3);
      send_sample(v, ok_status(), 1'($urandom));
    end
    if (broken) send_sample(v ^ RANGE_W'($urandom_range(1, 8191)), ok_status(), 1'($urandom));
    freeze_at = now_q;
    // after a freeze, samples inside the wait are answered invalid and dropped
    if (cur_wait > 0) begin
      repeat ($urandom_range(0, 3)) begin
        now_q = freeze_at + $urandom_range(0, cur_wait - 1);
        send_sample(RANGE_W'($urandom), 4'($urandom), 1'($urandom));
      end
    end
    now_q = freeze_at + cur_wait + $urandom_range(0, 2);
    send_sample(RANGE_W'($urandom), 4'($urandom), 1'($urandom));
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 19) == 0) now_q = $urandom;
      else now_q = now_q + $urandom_range(0, 50);
      send_sample(RANGE_W'($urandom), 4'($urandom), 1'($urandom));
    end
  endtask

  task automatic run_phase(input int unsigned in_pct, input int unsigned out_pct,
                           input int unsigned target);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    while (items_sent < target) begin
      if ($urandom_range(0, 29) == 0) drain();
      if ($urandom_range(0, 3) != 0) freeze_run();
      else noise_burst();
    end
  endtask

  initial begin
    logic [TIME_W-1:0] freeze_at;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, phase failure, freeze, wait across the time wrap
    now_q = '0;
    send_sample('0, '0, 1'b1);
    now_q = 1;
    send_sample(OUT_OF_RANGE_MM, '1, 1'b0);
    now_q = 2;
    send_sample(13'd100, PHASE_FAIL_STATUS, 1'b1);
    for (int i = 0; i < WINDOW_LEN_DEF; i++) begin
      now_q = 32'hFFFF_FF00 + i;
      send_sample(RANGE_W'(OUT_OF_RANGE_MM - 1), ok_status(), i[0]);
    end
    freeze_at = now_q;
    now_q = freeze_at + WAIT_RESET - 1;
    send_sample(13'd5, '0, 1'b0);
    now_q = freeze_at + WAIT_RESET;
    send_sample(13'd7, ok_status(), 1'b1);

    // Random: largest offset, zero wait
    drain();
    reg_write(REG_OFFSET, '1);
    reg_write(REG_WAIT, '0);
    cur_wait = 0;
    run_phase(37, 85, 385);

    // Random: random offset, longest wait
    drain();
    reg_write(REG_OFFSET, CFG_W'($urandom));
    reg_write(REG_WAIT, '1);
    cur_wait = 65535;
    run_phase(85, 37, 745);

    // Random: no offset, short wait, no idling
    drain();
    cur_wait = $urandom_range(1, 40);
    reg_write(REG_OFFSET, '0);
    reg_write(REG_WAIT, CFG_W'(cur_wait));
    run_phase(0, 0, 1105);

    drain();
    repeat (12) @(posedge clk_i);
    if (n_fail == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
